FILE: rtl/sesch_pkg.sv
package sesch_pkg;

   // Field widths fixed by the item format.
   localparam int FLOOR_W = 4;
   localparam int CNT_W   = 5;
   localparam int ACT_W   = 2;

   // Defaults for the top-level parameters.
   localparam int DEF_TOP_FLOOR   = 9;
   localparam int DEF_RIDER_SLOTS = 16;
   localparam int DEF_CALL_SLOTS  = 16;

   typedef logic [FLOOR_W-1:0] floor_type;
   typedef logic [ACT_W-1:0]   action_type;
   typedef logic [CNT_W-1:0]   count_type;

   // Item actions.
   localparam action_type ACT_TICK  = 2'd0;
   localparam action_type ACT_CALL  = 2'd1;
   localparam action_type ACT_RIDER = 2'd2;

   localparam floor_type BOTTOM_FLOOR = 4'd1;

   // Nearest requested floor above and below the car, as gathered during a scan.
   typedef struct packed {
      floor_type above;
      floor_type below;
   } bounds_type;

   // Folds one requested floor into the running bounds.
   function automatic bounds_type consider_floor(bounds_type b, floor_type car, floor_type f);
      bounds_type r;
      r = b;
      if (b.above > f && car < f) begin
         r.above = f;
      end else if (b.below < f && car > f) begin
         r.below = f;
      end
      return r;
   endfunction

endpackage

FILE: rtl/sesch_table.sv
module sesch_table #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 4,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data,
   output logic             rd_valid,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             clr_en,
   input  logic [AW-1:0]    clr_addr,
   output logic             free_found,
   output logic [AW-1:0]    free_addr,
   output logic             any_valid
);

   logic [WIDTH-1:0] entry_mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;
   logic             rd_valid_ff;
   logic [DEPTH-1:0] valid_ff;
   logic [DEPTH-1:0] valid_in;

   // Synchronous memory: one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      rd_data_ff  <= entry_mem[rd_addr];
      rd_valid_ff <= valid_ff[rd_addr];
   end

   assign rd_data  = rd_data_ff;
   assign rd_valid = rd_valid_ff;

   // Valid bits: a write sets its entry and a clear drops one.
   always_comb begin
      valid_in = valid_ff;
      if (clr_en) begin
         valid_in[clr_addr] = 1'b0;
      end
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Lowest free slot.
   always_comb begin
      free_found = 1'b0;
      free_addr  = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_addr  = AW'(i);
         end
      end
   end

   assign any_valid = |valid_ff;

endmodule

FILE: rtl/sesch_seq.sv
module sesch_seq #(
   parameter int TOP_FLOOR   = 9,
   parameter int RIDER_SLOTS = 16,
   parameter int CALL_SLOTS  = 16,
   localparam int RAW = (RIDER_SLOTS > 1) ? $clog2(RIDER_SLOTS) : 1,
   localparam int CAW = (CALL_SLOTS > 1) ? $clog2(CALL_SLOTS) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  sesch_pkg::action_type  req_action,
   input  sesch_pkg::floor_type   req_start_floor,
   input  sesch_pkg::floor_type   req_dest_floor,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output sesch_pkg::floor_type   rsp_car_floor_now,
   output logic                   rsp_moving_up,
   output sesch_pkg::count_type   rsp_left_count,
   output sesch_pkg::count_type   rsp_boarded_count,
   output logic                   rsp_idle,
   output logic                   rsp_accepted,
   // Rider table
   output logic [RAW-1:0]         rider_rd_addr,
   input  sesch_pkg::floor_type   rider_rd_data,
   input  logic                   rider_rd_valid,
   output logic                   rider_wr_en,
   output logic [RAW-1:0]         rider_wr_addr,
   output sesch_pkg::floor_type   rider_wr_data,
   output logic                   rider_clr_en,
   output logic [RAW-1:0]         rider_clr_addr,
   input  logic                   rider_free_found,
   input  logic [RAW-1:0]         rider_free_addr,
   input  logic                   rider_any,
   // Call table: origin in the upper floor field, destination in the lower
   output logic [CAW-1:0]         call_rd_addr,
   input  logic [2*sesch_pkg::FLOOR_W-1:0] call_rd_data,
   input  logic                   call_rd_valid,
   output logic                   call_wr_en,
   output logic [CAW-1:0]         call_wr_addr,
   output logic [2*sesch_pkg::FLOOR_W-1:0] call_wr_data,
   output logic                   call_clr_en,
   output logic [CAW-1:0]         call_clr_addr,
   input  logic                   call_free_found,
   input  logic [CAW-1:0]         call_free_addr,
   input  logic                   call_any
);

   import sesch_pkg::*;

   localparam int IW = (RAW > CAW) ? RAW : CAW;
   localparam floor_type TOP_F = floor_type'(TOP_FLOOR);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_RSCAN = 3'd1;
   localparam logic [2:0] S_CSCAN = 3'd2;
   localparam logic [2:0] S_DRAIN = 3'd3;
   localparam logic [2:0] S_FIN   = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   logic [2:0]  state_ff, state_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [IW-1:0] prc_idx_ff, prc_idx_in;
   logic        prc_rider_ff, prc_rider_in;
   logic        prc_call_ff, prc_call_in;
   floor_type   car_ff, car_in;
   logic        up_ff, up_in;
   bounds_type  bnd_ff, bnd_in;
   count_type   left_ff, left_in;
   count_type   board_ff, board_in;
   logic        idle_ff, idle_in;
   logic        acc_ff, acc_in;

   logic        rsp_valid_ff, rsp_valid_in;
   floor_type   rsp_car_ff;
   logic        rsp_up_ff;
   count_type   rsp_left_ff;
   count_type   rsp_board_ff;
   logic        rsp_idle_ff;
   logic        rsp_acc_ff;

   logic        accept;
   logic        out_free;
   logic        load_rsp;
   logic        start_ok;
   logic        dest_ok;
   floor_type   call_origin;
   floor_type   call_dest;
   floor_type   next_floor;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign load_rsp  = (state_ff == S_OUT) && out_free;

   assign start_ok = (req_start_floor >= BOTTOM_FLOOR) && (req_start_floor <= TOP_F);
   assign dest_ok  = (req_dest_floor >= BOTTOM_FLOOR) && (req_dest_floor <= TOP_F);

   assign call_origin = call_rd_data[2*FLOOR_W-1:FLOOR_W];
   assign call_dest   = call_rd_data[FLOOR_W-1:0];

   assign rider_rd_addr = idx_ff[RAW-1:0];
   assign call_rd_addr  = idx_ff[CAW-1:0];

   // SCAN choice of the next floor from the gathered bounds.
   always_comb begin
      if (up_ff && car_ff == TOP_F) begin
         next_floor = bnd_ff.below;
      end else if (!up_ff && car_ff == BOTTOM_FLOOR) begin
         next_floor = bnd_ff.above;
      end else if (up_ff && bnd_ff.above > car_ff) begin
         next_floor = bnd_ff.above;
      end else begin
         next_floor = bnd_ff.below;
      end
   end

   // Sequencer and scan datapath.
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      prc_idx_in   = idx_ff;
      prc_rider_in = 1'b0;
      prc_call_in  = 1'b0;
      car_in       = car_ff;
      up_in        = up_ff;
      bnd_in       = bnd_ff;
      left_in      = left_ff;
      board_in     = board_ff;
      idle_in      = idle_ff;
      acc_in       = acc_ff;

      rider_wr_en    = 1'b0;
      rider_wr_addr  = rider_free_addr;
      rider_wr_data  = req_dest_floor;
      rider_clr_en   = 1'b0;
      rider_clr_addr = prc_idx_ff[RAW-1:0];
      call_wr_en     = 1'b0;
      call_wr_addr   = call_free_addr;
      call_wr_data   = {req_start_floor, req_dest_floor};
      call_clr_en    = 1'b0;
      call_clr_addr  = prc_idx_ff[CAW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               left_in  = '0;
               board_in = '0;
               idle_in  = 1'b0;
               case (req_action)
                  ACT_TICK: begin
                     acc_in   = 1'b1;
                     idx_in   = '0;
                     bnd_in   = '{above: TOP_F, below: BOTTOM_FLOOR};
                     state_in = S_RSCAN;
                  end
                  ACT_CALL: begin
                     acc_in     = start_ok && dest_ok && call_free_found;
                     call_wr_en = start_ok && dest_ok && call_free_found;
                     state_in   = S_OUT;
                  end
                  ACT_RIDER: begin
                     acc_in      = dest_ok && rider_free_found;
                     rider_wr_en = dest_ok && rider_free_found;
                     state_in    = S_OUT;
                  end
                  default: begin
                     acc_in   = 1'b0;
                     state_in = S_OUT;
                  end
               endcase
            end
         end
         S_RSCAN: begin
            prc_rider_in = 1'b1;
            if (idx_ff == IW'(RIDER_SLOTS - 1)) begin
               idx_in   = '0;
               state_in = S_CSCAN;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_CSCAN: begin
            prc_call_in = 1'b1;
            if (idx_ff == IW'(CALL_SLOTS - 1)) begin
               state_in = S_DRAIN;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            state_in = S_FIN;
         end
         S_FIN: begin
            idle_in = !rider_any && !call_any;
            if (rider_any || call_any) begin
               car_in = next_floor;
               if (up_ff && next_floor < car_ff) begin
                  up_in = 1'b0;
               end else if (!up_ff && next_floor > car_ff) begin
                  up_in = 1'b1;
               end
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // A rider entry read back from the table: leaves here or marks its floor.
      if (prc_rider_ff && rider_rd_valid) begin
         if (rider_rd_data == car_ff) begin
            rider_clr_en = 1'b1;
            left_in      = left_ff + 1'b1;
         end else begin
            bnd_in = consider_floor(bnd_ff, car_ff, rider_rd_data);
         end
      end

      // A call entry: boards when it waits at the car's floor and a rider slot is free, otherwise keeps waiting.
      if (prc_call_ff && call_rd_valid) begin
         if (call_origin == car_ff && rider_free_found) begin
            rider_wr_en   = 1'b1;
            rider_wr_addr = rider_free_addr;
            rider_wr_data = call_dest;
            call_clr_en   = 1'b1;
            board_in      = board_ff + 1'b1;
            bnd_in        = consider_floor(bnd_ff, car_ff, call_dest);
         end else begin
            bnd_in = consider_floor(bnd_ff, car_ff, call_origin);
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         prc_rider_ff <= 1'b0;
         prc_call_ff  <= 1'b0;
         car_ff       <= BOTTOM_FLOOR;
         up_ff        <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prc_rider_ff <= prc_rider_in;
         prc_call_ff  <= prc_call_in;
         car_ff       <= car_in;
         up_ff        <= up_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      prc_idx_ff <= prc_idx_in;
      bnd_ff     <= bnd_in;
      left_ff    <= left_in;
      board_ff   <= board_in;
      idle_ff    <= idle_in;
      acc_ff     <= acc_in;
   end

   // Output register: holds a finished beat until it is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_car_ff   <= car_ff;
         rsp_up_ff    <= up_ff;
         rsp_left_ff  <= left_ff;
         rsp_board_ff <= board_ff;
         rsp_idle_ff  <= idle_ff;
         rsp_acc_ff   <= acc_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_car_floor_now = rsp_car_ff;
   assign rsp_moving_up     = rsp_up_ff;
   assign rsp_left_count    = rsp_left_ff;
   assign rsp_boarded_count = rsp_board_ff;
   assign rsp_idle          = rsp_idle_ff;
   assign rsp_accepted      = rsp_acc_ff;

endmodule

FILE: rtl/scan_elevator_scheduler_top.sv
// An add (waiting call or rider) goes from acceptance to the output state and then into
// the output register. A tick walks the rider table and then the call table, one entry
// per cycle through the single read port of each table, then drains, updates the car and
// loads the output register. One item is in progress at a time; the next is taken once
// its result is in the output register, and an output stall holds the item until then.
// Synchronous reset empties both tables, puts the car at floor 1 and sets it moving up.
module scan_elevator_scheduler_top #(
   parameter int TOP_FLOOR   = sesch_pkg::DEF_TOP_FLOOR,
   parameter int RIDER_SLOTS = sesch_pkg::DEF_RIDER_SLOTS,
   parameter int CALL_SLOTS  = sesch_pkg::DEF_CALL_SLOTS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  sesch_pkg::action_type req_action,
   input  sesch_pkg::floor_type  req_start_floor,
   input  sesch_pkg::floor_type  req_dest_floor,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output sesch_pkg::floor_type  rsp_car_floor_now,
   output logic                  rsp_moving_up,
   output sesch_pkg::count_type  rsp_left_count,
   output sesch_pkg::count_type  rsp_boarded_count,
   output logic                  rsp_idle,
   output logic                  rsp_accepted
);

   import sesch_pkg::*;

   localparam int RAW = (RIDER_SLOTS > 1) ? $clog2(RIDER_SLOTS) : 1;
   localparam int CAW = (CALL_SLOTS > 1) ? $clog2(CALL_SLOTS) : 1;
   localparam int CW  = 2 * FLOOR_W;

   logic [RAW-1:0] rider_rd_addr;
   floor_type      rider_rd_data;
   logic           rider_rd_valid;
   logic           rider_wr_en;
   logic [RAW-1:0] rider_wr_addr;
   floor_type      rider_wr_data;
   logic           rider_clr_en;
   logic [RAW-1:0] rider_clr_addr;
   logic           rider_free_found;
   logic [RAW-1:0] rider_free_addr;
   logic           rider_any;

   logic [CAW-1:0] call_rd_addr;
   logic [CW-1:0]  call_rd_data;
   logic           call_rd_valid;
   logic           call_wr_en;
   logic [CAW-1:0] call_wr_addr;
   logic [CW-1:0]  call_wr_data;
   logic           call_clr_en;
   logic [CAW-1:0] call_clr_addr;
   logic           call_free_found;
   logic [CAW-1:0] call_free_addr;
   logic           call_any;

   // Riders in the car: destination floor per slot.
   sesch_table #(
      .DEPTH (RIDER_SLOTS),
      .WIDTH (FLOOR_W)
   ) u_rider_table (
      .clock      (clock),
      .reset      (reset),
      .rd_addr    (rider_rd_addr),
      .rd_data    (rider_rd_data),
      .rd_valid   (rider_rd_valid),
      .wr_en      (rider_wr_en),
      .wr_addr    (rider_wr_addr),
      .wr_data    (rider_wr_data),
      .clr_en     (rider_clr_en),
      .clr_addr   (rider_clr_addr),
      .free_found (rider_free_found),
      .free_addr  (rider_free_addr),
      .any_valid  (rider_any)
   );

   // Waiting calls: origin and destination floor per slot.
   sesch_table #(
      .DEPTH (CALL_SLOTS),
      .WIDTH (CW)
   ) u_call_table (
      .clock      (clock),
      .reset      (reset),
      .rd_addr    (call_rd_addr),
      .rd_data    (call_rd_data),
      .rd_valid   (call_rd_valid),
      .wr_en      (call_wr_en),
      .wr_addr    (call_wr_addr),
      .wr_data    (call_wr_data),
      .clr_en     (call_clr_en),
      .clr_addr   (call_clr_addr),
      .free_found (call_free_found),
      .free_addr  (call_free_addr),
      .any_valid  (call_any)
   );

   // Item sequencer, table walk and output register.
   sesch_seq #(
      .TOP_FLOOR   (TOP_FLOOR),
      .RIDER_SLOTS (RIDER_SLOTS),
      .CALL_SLOTS  (CALL_SLOTS)
   ) u_seq (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_start_floor   (req_start_floor),
      .req_dest_floor    (req_dest_floor),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_car_floor_now (rsp_car_floor_now),
      .rsp_moving_up     (rsp_moving_up),
      .rsp_left_count    (rsp_left_count),
      .rsp_boarded_count (rsp_boarded_count),
      .rsp_idle          (rsp_idle),
      .rsp_accepted      (rsp_accepted),
      .rider_rd_addr     (rider_rd_addr),
      .rider_rd_data     (rider_rd_data),
      .rider_rd_valid    (rider_rd_valid),
      .rider_wr_en       (rider_wr_en),
      .rider_wr_addr     (rider_wr_addr),
      .rider_wr_data     (rider_wr_data),
      .rider_clr_en      (rider_clr_en),
      .rider_clr_addr    (rider_clr_addr),
      .rider_free_found  (rider_free_found),
      .rider_free_addr   (rider_free_addr),
      .rider_any         (rider_any),
      .call_rd_addr      (call_rd_addr),
      .call_rd_data      (call_rd_data),
      .call_rd_valid     (call_rd_valid),
      .call_wr_en        (call_wr_en),
      .call_wr_addr      (call_wr_addr),
      .call_wr_data      (call_wr_data),
      .call_clr_en       (call_clr_en),
      .call_clr_addr     (call_clr_addr),
      .call_free_found   (call_free_found),
      .call_free_addr    (call_free_addr),
      .call_any          (call_any)
   );

endmodule
